/* hw/rtl/tsa_pkg.sv */
// Shared types, constants and helpers for the transmit ring space allocator.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
package tsa_pkg;

  localparam int unsigned AddrW     = 13;
  localparam int unsigned PtrW      = 14;
  localparam int unsigned EndW      = 14;
  localparam int unsigned SumW      = 15;
  localparam int unsigned RamBytes  = 8192;

  localparam logic [AddrW-1:0] DefaultStart = 13'd4096;
  localparam logic [PtrW-1:0]  TxOverhead   = 14'd8;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_CONFIRM = 1'b1
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [AddrW-1:0] frame_size;
    logic [AddrW-1:0] sent_frame_end;
  } tsa_req_t;

  typedef struct packed {
    logic             granted;
    logic [AddrW-1:0] frame_start;
    logic [EndW-1:0]  frame_end;
  } tsa_result_t;

  function automatic logic [PtrW-1:0] round_even(input logic [PtrW-1:0] v);
    logic [PtrW-1:0] s;
    s = v + 14'd1;
    return {s[PtrW-1:1], 1'b0};
  endfunction

endpackage

/* hw/rtl/tsa_input_reg.sv */
// Input register stage of the allocator: holds one accepted request item.
// Depends on tsa_pkg for the request type.
`timescale 1ns / 1ps
module tsa_input_reg
  import tsa_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tsa_req_t in_req_i,
  input  logic     pop_i,
  output logic     valid_o,
  output tsa_req_t req_o
);

  logic     valid_q, valid_d;
  tsa_req_t req_q, req_d;
  logic     load;

  assign in_ready_o = !valid_q || pop_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    req_d   = req_q;
    if (load) begin
      valid_d = 1'b1;
      req_d   = in_req_i;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

  ap_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_q)
    else $error("pop without a held item");

endmodule

/* hw/rtl/tsa_engine.sv */
// Pointer state and allocation logic: region start, write and release pointers.
// Depends on tsa_pkg for types, constants and the even rounding helper.
`timescale 1ns / 1ps
module tsa_engine
  import tsa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AddrW-1:0] cfg_wdata_i,
  input  logic             step_i,
  input  tsa_req_t         req_i,
  output tsa_result_t      result_o
);

  logic [AddrW-1:0] start_q, start_d;
  logic [PtrW-1:0]  wp_q, wp_d;
  logic [PtrW-1:0]  rp_q, rp_d;

  logic [PtrW-1:0]  start_ext;
  logic [SumW-1:0]  need_raw;
  logic [SumW-1:0]  need_eff;
  logic [PtrW-1:0]  w_eff;
  logic [PtrW-1:0]  end_ptr;
  logic             wrap_chk;
  logic             refuse_end;
  logic             refuse_rp;
  logic             granted;

  assign start_ext = PtrW'(start_q);

  always_comb begin
    need_raw   = SumW'(wp_q) + SumW'(req_i.frame_size) + SumW'(TxOverhead);
    wrap_chk   = (wp_q >= rp_q) && (32'(need_raw) > RamBytes);
    refuse_end = wrap_chk && (rp_q == start_ext);
    w_eff      = (wrap_chk && !refuse_end) ? start_ext : wp_q;
    need_eff   = SumW'(w_eff) + SumW'(req_i.frame_size) + SumW'(TxOverhead);
    refuse_rp  = (w_eff < rp_q) && (need_eff >= SumW'(rp_q));
    granted    = !refuse_end && !refuse_rp;
    end_ptr    = w_eff + PtrW'(req_i.frame_size);

    result_o.granted     = granted;
    result_o.frame_start = granted ? w_eff[AddrW-1:0] : '0;
    result_o.frame_end   = granted ? EndW'(end_ptr) : '0;
  end

  always_comb begin
    start_d = start_q;
    wp_d    = wp_q;
    rp_d    = rp_q;
    if (cfg_we_i) begin
      start_d = cfg_wdata_i;
      wp_d    = PtrW'(cfg_wdata_i);
      rp_d    = PtrW'(cfg_wdata_i);
    end else if (step_i) begin
      case (req_i.op)
        OP_CONFIRM: begin
          rp_d = round_even(PtrW'(req_i.sent_frame_end) + TxOverhead);
        end
        OP_ALLOC: begin
          wp_d = granted ? round_even(end_ptr + TxOverhead) : w_eff;
        end
        default: begin
          wp_d = wp_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= DefaultStart;
      wp_q    <= PtrW'(DefaultStart);
      rp_q    <= PtrW'(DefaultStart);
    end else begin
      start_q <= start_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
    end
  end

  ap_confirm_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && req_i.op == OP_CONFIRM && !cfg_we_i) |=> (rp_q[0] == 1'b0))
    else $error("release pointer odd after confirm");

  ap_grant_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && req_i.op == OP_ALLOC && granted && !cfg_we_i) |=> (wp_q[0] == 1'b0))
    else $error("write pointer odd after grant");

  ap_cfg_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (wp_q == rp_q) && (wp_q == start_ext))
    else $error("pointers not reloaded by start write");

endmodule

/* hw/rtl/tx_ring_space_allocator.sv */
// Transmit ring space allocator, top level: input stage, engine, result register.
// Depends on tsa_pkg, tsa_input_reg and tsa_engine.
// Path: an allocate item is held in the input stage, then its result is registered.
// Throughput: one item per cycle; a confirm item yields no result, and an
// allocate item waits in the input stage while an earlier result is stalled.
// Reset: region start, write and release pointers all return to address 4096.
`timescale 1ns / 1ps
module tx_ring_space_allocator
  import tsa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [AddrW-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // [12:0] frame_size, [25:13] sent_frame_end, [31:26] zero
  input  logic [31:0]      s_axis_tdata,
  // [0] opcode
  input  logic             s_axis_tuser,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // [12:0] frame_start, [26:13] frame_end, [31:27] zero
  output logic [31:0]      m_axis_tdata,
  // [0] granted
  output logic             m_axis_tuser
);

  tsa_req_t    in_req;
  tsa_req_t    held_req;
  logic        held_valid;
  logic        step;
  tsa_result_t result;

  tsa_result_t out_q, out_d;
  logic        out_valid_q, out_valid_d;
  logic        out_load;

  assign in_req.op             = op_e'(s_axis_tuser);
  assign in_req.frame_size     = s_axis_tdata[12:0];
  assign in_req.sent_frame_end = s_axis_tdata[25:13];

  tsa_input_reg u_input_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_req_i   (in_req),
    .pop_i      (step),
    .valid_o    (held_valid),
    .req_o      (held_req)
  );

  assign step = held_valid &&
                (held_req.op == OP_CONFIRM || !out_valid_q || m_axis_tready);
  assign out_load = step && (held_req.op == OP_ALLOC);

  tsa_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .req_i       (held_req),
    .result_o    (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_d       = result;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.granted;
  assign m_axis_tdata  = {5'd0, out_q.frame_end, out_q.frame_start};

  ap_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !out_q.granted) |->
      (out_q.frame_start == '0) && (out_q.frame_end == '0))
    else $error("refused item carries nonzero addresses");

  ap_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !out_load)
    else $error("result register overwritten while stalled");

endmodule
